### design/rlkd_pkg.sv
// ----------------------------------------------------------------------------
// rlkd_pkg
// Shared constants, types and the ladder threshold table for the resistor
// ladder key debouncer.
// ----------------------------------------------------------------------------
package rlkd_pkg;

    // Sizes of the button set and of the payload fields.
    localparam int NUM_BUTTONS   = 10;
    localparam int LADDER_A_KEYS = 2;
    localparam int LADDER_B_KEYS = 8;
    localparam int SAMPLE_W      = 12;
    localparam int IDX_W         = 4;
    localparam int HOLD_W        = 8;
    localparam int SLOT_W        = 3;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;
    localparam logic [IDX_W-1:0]  LAST_IDX = 4'(NUM_BUTTONS - 1);
    localparam logic [IDX_W-1:0]  A_KEYS_IDX = 4'(LADDER_A_KEYS);

    // Sequencer states.
    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // Update request from the sequencer to the button bank.
    typedef struct packed
    {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             raw_bit;
        logic             clear;
    } btn_upd_t;

    // Updated status of the button that is being processed.
    typedef struct packed
    {
        logic              is_pressed;
        logic              press_seen;
        logic              release_seen;
        logic [HOLD_W-1:0] hold_scans;
    } btn_status_t;

    // Ascending ladder thresholds, shared by both ladders.
    function automatic logic [SAMPLE_W-1:0] ladder_limit(input logic [SLOT_W-1:0] slot);
        logic [SAMPLE_W-1:0] lim;
        case (slot)
            3'd0:    lim = 12'd46;
            3'd1:    lim = 12'd132;
            3'd2:    lim = 12'd203;
            3'd3:    lim = 12'd264;
            3'd4:    lim = 12'd317;
            3'd5:    lim = 12'd362;
            3'd6:    lim = 12'd401;
            3'd7:    lim = 12'd438;
            default: lim = 12'd438;
        endcase
        return lim;
    endfunction

endpackage

### design/rlkd_scan_if.sv
// ----------------------------------------------------------------------------
// rlkd_scan_if
// Scan channel: two ladder samples and the flag clear request per transfer.
// ----------------------------------------------------------------------------
interface rlkd_scan_if;
    import rlkd_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] ladder_a_sample;
    logic [SAMPLE_W-1:0] ladder_b_sample;
    logic                clear_edge_flags;

    modport source
    (
        output valid,
        output ladder_a_sample,
        output ladder_b_sample,
        output clear_edge_flags,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  ladder_a_sample,
        input  ladder_b_sample,
        input  clear_edge_flags,
        output ready
    );

endinterface

### design/rlkd_result_if.sv
// ----------------------------------------------------------------------------
// rlkd_result_if
// Result channel: the status of one button per transfer.
// ----------------------------------------------------------------------------
interface rlkd_result_if;
    import rlkd_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  button_index;
    logic              is_pressed;
    logic              press_seen;
    logic              release_seen;
    logic [HOLD_W-1:0] hold_scans;
    logic              last_of_scan;

    modport source
    (
        output valid,
        output button_index,
        output is_pressed,
        output press_seen,
        output release_seen,
        output hold_scans,
        output last_of_scan,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  button_index,
        input  is_pressed,
        input  press_seen,
        input  release_seen,
        input  hold_scans,
        input  last_of_scan,
        output ready
    );

endinterface

### design/rlkd_ladder_cmp.sv
// ----------------------------------------------------------------------------
// rlkd_ladder_cmp
// Shared threshold comparator. It walks one button per step and reports the
// raw level of that button: the first threshold of its ladder that the
// sample lies below.
// ----------------------------------------------------------------------------
module rlkd_ladder_cmp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          step,
    input  logic [rlkd_pkg::IDX_W-1:0]    idx,
    input  logic [rlkd_pkg::SAMPLE_W-1:0] sample_a,
    input  logic [rlkd_pkg::SAMPLE_W-1:0] sample_b,
    output logic                          raw_bit
);
    import rlkd_pkg::*;

    logic                found_a_reg;
    logic                found_a_next;
    logic                found_b_reg;
    logic                found_b_next;
    logic                on_a;
    logic [IDX_W-1:0]    b_pos;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
    logic                below;

    // Select the ladder and the threshold slot for this button.
    always_comb
    begin
        on_a   = (idx < A_KEYS_IDX);
        b_pos  = idx - A_KEYS_IDX;
        slot   = on_a ? idx[SLOT_W-1:0] : b_pos[SLOT_W-1:0];
        sample = on_a ? sample_a : sample_b;
        below  = (sample < ladder_limit(slot));
        raw_bit = below && !(on_a ? found_a_reg : found_b_reg);
    end

    // Remember whether a lower threshold of each ladder already matched.
    always_comb
    begin
        found_a_next = found_a_reg;
        found_b_next = found_b_reg;
        if (start)
        begin
            found_a_next = 1'b0;
            found_b_next = 1'b0;
        end
        else if (step)
        begin
            if (on_a)
            begin
                found_a_next = found_a_reg | below;
            end
            else
            begin
                found_b_next = found_b_reg | below;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
        end
        else
        begin
            found_a_reg <= found_a_next;
            found_b_reg <= found_b_next;
        end
    end

endmodule

### design/rlkd_btn_bank.sv
// ----------------------------------------------------------------------------
// rlkd_btn_bank
// Per-button debounce state: previous raw level, debounced level, sticky
// press and release flags and hold counters, updated one button per step.
// ----------------------------------------------------------------------------
module rlkd_btn_bank
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rlkd_pkg::btn_upd_t    upd,
    output rlkd_pkg::btn_status_t status
);
    import rlkd_pkg::*;

    logic [NUM_BUTTONS-1:0] raw_prev_reg;
    logic [NUM_BUTTONS-1:0] level_reg;
    logic [NUM_BUTTONS-1:0] press_reg;
    logic [NUM_BUTTONS-1:0] release_reg;
    logic [HOLD_W-1:0]      hold_reg [NUM_BUTTONS];

    logic              level_old;
    logic              level_new;
    logic              changed;
    logic [HOLD_W-1:0] hold_old;
    logic [HOLD_W-1:0] hold_next;
    logic              press_next;
    logic              release_next;

    // Debounce rule and flag and timer update for the selected button.
    always_comb
    begin
        level_old = level_reg[upd.idx];
        hold_old  = hold_reg[upd.idx];
        level_new = (upd.raw_bit == raw_prev_reg[upd.idx]) ? upd.raw_bit : level_old;
        changed   = (level_new != level_old);
        if (changed)
        begin
            hold_next = '0;
        end
        else if (hold_old == HOLD_MAX)
        begin
            hold_next = HOLD_MAX;
        end
        else
        begin
            hold_next = hold_old + 8'd1;
        end
        press_next   = (!upd.clear && press_reg[upd.idx]) || (changed && level_new);
        release_next = (!upd.clear && release_reg[upd.idx]) || (changed && !level_new);

        status.is_pressed   = level_new;
        status.press_seen   = press_next;
        status.release_seen = release_next;
        status.hold_scans   = hold_next;
    end

    // Write the selected button back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= '0;
            level_reg    <= '0;
            press_reg    <= '0;
            release_reg  <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else if (upd.en)
        begin
            raw_prev_reg[upd.idx] <= upd.raw_bit;
            level_reg[upd.idx]    <= level_new;
            press_reg[upd.idx]    <= press_next;
            release_reg[upd.idx]  <= release_next;
            hold_reg[upd.idx]     <= hold_next;
        end
    end

endmodule

### design/resistor_ladder_key_debouncer_unit.sv
// ----------------------------------------------------------------------------
// resistor_ladder_key_debouncer_unit
// Decodes two resistor ladder samples into ten buttons, debounces them and
// reports one status result per button for every scan.
// ----------------------------------------------------------------------------
// A transfer moves the sequencer to its run state; each button step loads
// the result output register. No scan is taken until the last button is
// done; the shared comparator and bank do one button a cycle while free.
// Reset (rst_n, asynchronous, active low) clears all button state, flags and
// hold timers, and leaves the block idle and ready for a scan.
// ----------------------------------------------------------------------------
module resistor_ladder_key_debouncer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    rlkd_scan_if.sink  scan,
    rlkd_result_if.source result
);
    import rlkd_pkg::*;

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [SAMPLE_W-1:0] a_reg;
    logic [SAMPLE_W-1:0] b_reg;
    logic                clear_reg;
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    btn_status_t         out_status_reg;
    logic                out_last_reg;

    logic        accept;
    logic        out_free;
    logic        step;
    logic        raw_bit;
    btn_upd_t    upd;
    btn_status_t status;

    // Shared comparator and button state bank.
    rlkd_ladder_cmp u_cmp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .step     (step),
        .idx      (idx_reg),
        .sample_a (a_reg),
        .sample_b (b_reg),
        .raw_bit  (raw_bit)
    );

    rlkd_btn_bank u_bank
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (upd),
        .status (status)
    );

    // Sequencer: take a scan when idle, then walk the ten buttons.
    always_comb
    begin
        out_free   = !out_valid_reg || result.ready;
        scan.ready = (state_reg == ST_IDLE);
        accept     = scan.valid && scan.ready;
        step       = (state_reg == ST_RUN) && out_free;

        upd.en      = step;
        upd.idx     = idx_reg;
        upd.raw_bit = raw_bit;
        upd.clear   = clear_reg;

        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (step)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Capture the scan payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg     <= scan.ladder_a_sample;
            b_reg     <= scan.ladder_b_sample;
            clear_reg <= scan.clear_edge_flags;
        end
    end

    // Result output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_idx_reg    <= idx_reg;
            out_status_reg <= status;
            out_last_reg   <= (idx_reg == LAST_IDX);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.button_index = out_idx_reg;
    assign result.is_pressed   = out_status_reg.is_pressed;
    assign result.press_seen   = out_status_reg.press_seen;
    assign result.release_seen = out_status_reg.release_seen;
    assign result.hold_scans   = out_status_reg.hold_scans;
    assign result.last_of_scan = out_last_reg;

    // A new scan always starts at the first button and blocks further scans.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (idx_reg == '0) && !scan.ready)
        else $error("scan did not start at button zero");

    // Finishing the last button returns the block to ready.
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (idx_reg == LAST_IDX)) |=> scan.ready)
        else $error("block not ready after last button");

    // The sequencer never addresses a button beyond the last one.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (idx_reg <= LAST_IDX))
        else $error("button index out of range");

    // The end-of-scan mark goes with the last button only.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.last_of_scan == (result.button_index == LAST_IDX)))
        else $error("end-of-scan mark on wrong button");

endmodule
